### sv/mrpr_pkg.sv
// Shared constants and types for the multiply-rotate random generator.
package mrpr_pkg;

    // Generator step: multiply constant and right-rotate distance.
    localparam logic [31:0] MULT  = 32'hDEADBF03;
    localparam int          ROT_R = 13;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] OP_SEED  = 2'd0;
    localparam logic [1:0] OP_RANGE = 2'd1;
    localparam logic [1:0] OP_BIT   = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

endpackage

### sv/multiply_rotate_prng_range.sv
// Top level of the multiply-rotate random generator with range and bit draws.
// Seed load: takes effect at accept. Bit draw: ST_MUL, then ST_OUT, then the output register.
// Range draw: ST_MUL, then ST_DIV for the 32 divider steps, then ST_OUT;
// a full-width range skips the divider and goes from ST_MUL to ST_OUT like a bit draw.
// One transaction is in work at a time; the input is not ready until it is done.
// Synchronous active-low reset clears the generator state to zero and empties the output.
module multiply_rotate_prng_range (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // seed_value[31:0], range_low[63:32], range_high[95:64]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // value[31:0]
);

    mrpr_pkg::t_state r_st;
    logic [31:0] r_rng;
    logic        r_is_range;
    logic [31:0] r_addend;
    logic [31:0] r_mod;
    logic [31:0] r_res;
    logic        r_out_valid;
    logic [31:0] r_out;

    logic        w_accept;
    logic [31:0] w_seed;
    logic [31:0] w_lo;
    logic [31:0] w_hi;
    logic [31:0] w_inc;
    logic [31:0] w_prod;
    logic [31:0] w_next;
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_div_rem;
    logic        w_out_free;

    assign w_seed = s_axis_tdata[31:0];
    assign w_lo   = s_axis_tdata[63:32];
    assign w_hi   = s_axis_tdata[95:64];

    assign s_axis_tready = (r_st == mrpr_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Generator step: add one, multiply modulo 2^32, rotate right.
    assign w_inc  = r_rng + 32'd1;
    assign w_prod = w_inc * mrpr_pkg::MULT;
    assign w_next = (w_prod >> mrpr_pkg::ROT_R) | (w_prod << (32 - mrpr_pkg::ROT_R));

    // The divider starts in ST_MUL, alongside the step, for a range draw whose modulus is nonzero.
    assign w_div_start = (r_st == mrpr_pkg::ST_MUL) && r_is_range && (r_mod != 32'd0);

    mrpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_next),
        .i_divisor  (r_mod),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Sequencer and generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= mrpr_pkg::ST_IDLE;
            r_rng <= '0;
        end else begin
            case (r_st)
                mrpr_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser == mrpr_pkg::OP_SEED) begin
                            r_rng <= w_seed;
                        end else if (s_axis_tuser == mrpr_pkg::OP_RANGE ||
                                     s_axis_tuser == mrpr_pkg::OP_BIT) begin
                            r_st <= mrpr_pkg::ST_MUL;
                        end
                    end
                end
                mrpr_pkg::ST_MUL: begin
                    r_rng <= w_next;
                    if (w_div_start) begin
                        r_st <= mrpr_pkg::ST_DIV;
                    end else begin
                        r_st <= mrpr_pkg::ST_OUT;
                    end
                end
                mrpr_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        r_st <= mrpr_pkg::ST_OUT;
                    end
                end
                mrpr_pkg::ST_OUT: begin
                    if (w_out_free) begin
                        r_st <= mrpr_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_st <= mrpr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Operands latched at accept, and the pre-add result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_range <= (s_axis_tuser == mrpr_pkg::OP_RANGE);
            r_addend   <= (s_axis_tuser == mrpr_pkg::OP_RANGE) ? w_lo : 32'd0;
            r_mod      <= w_hi - w_lo + 32'd1;
        end
        if (r_st == mrpr_pkg::ST_MUL) begin
            if (r_is_range) begin
                r_res <= w_next;
            end else begin
                r_res <= {31'd0, w_next[0]};
            end
        end else if (r_st == mrpr_pkg::ST_DIV && w_div_done) begin
            r_res <= w_div_rem;
        end
    end

    // Output register: the final add happens as the result is loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_st == mrpr_pkg::ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == mrpr_pkg::ST_OUT && w_out_free) begin
            r_out <= r_res + r_addend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

### sv/mrpr_div.sv
// Radix-2 restoring divider that returns the 32-bit remainder, one bit per cycle.
module mrpr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [31:0] r_dsr;
    logic [31:0] r_rem;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign w_trial = {r_rem, r_dvd[31]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    // Control: busy flag, bit counter and a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifter and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
            end else begin
                r_rem <= w_trial[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
